// ===== hdl/rpv_pkg.sv =====
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, register codes and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package rpv_pkg;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_CENTER_X        = 2'd0,
      REG_CENTER_Y        = 2'd1,
      REG_FOCAL_SCALE     = 2'd2,
      REG_VIEWER_DISTANCE = 2'd3
   } reg_index_type;

   localparam logic [7:0]  CENTER_X_RESET        = 8'd64;
   localparam logic [7:0]  CENTER_Y_RESET        = 8'd32;
   localparam logic [11:0] FOCAL_SCALE_RESET     = 12'd1000;
   localparam logic [11:0] VIEWER_DISTANCE_RESET = 12'd1100;

   // coordinate width through the rotations (|v| <= 128*sqrt(3))
   localparam int COORD_W = 10;
   // numerator magnitude: 4095 * 222 fits in 20 bits
   localparam int NUM_W   = 20;
   localparam int DEN_W   = 13;

   function automatic logic [16:0] cos_q16(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd65220;
         5'd2:  v = 17'd64277;
         5'd3:  v = 17'd62714;
         5'd4:  v = 17'd60547;
         5'd5:  v = 17'd57798;
         5'd6:  v = 17'd54491;
         5'd7:  v = 17'd50660;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd41576;
         5'd10: v = 17'd36410;
         5'd11: v = 17'd30893;
         5'd12: v = 17'd25080;
         5'd13: v = 17'd19024;
         5'd14: v = 17'd12785;
         5'd15: v = 17'd6424;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/rpv_rotate.sv =====
// ----------------------------------------------------------------------------
// rpv_rotate
// One plane rotation stage: a' = trunc(c*a - s*b), b' = trunc(c*b + s*a).
// Two register levels: products, then sum and truncation toward zero.
// ----------------------------------------------------------------------------
module rpv_rotate #(
   parameter int FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [5:0]                         angle,
   input  logic signed [rpv_pkg::COORD_W-1:0] a_in,
   input  logic signed [rpv_pkg::COORD_W-1:0] b_in,
   output logic signed [rpv_pkg::COORD_W-1:0] a_out,
   output logic signed [rpv_pkg::COORD_W-1:0] b_out
);

   localparam int SH   = 16 - FRAC_BITS;
   localparam int TW   = FRAC_BITS + 2;
   localparam int PW   = TW + rpv_pkg::COORD_W;
   localparam int SW   = PW + 1;

   logic [3:0]          r;
   logic [1:0]          q;
   logic [4:0]          rc;
   logic [16:0]         t_r_raw;
   logic [16:0]         t_c_raw;
   logic [17:0]         t_r_rnd;
   logic [17:0]         t_c_rnd;
   logic signed [TW-1:0] t_r;
   logic signed [TW-1:0] t_c;
   logic signed [TW-1:0] cs;
   logic signed [TW-1:0] sn;

   logic signed [PW-1:0] ca_ff, sb_ff, cb_ff, sa_ff;
   logic signed [PW-1:0] ca_in, sb_in, cb_in, sa_in;
   logic signed [SW-1:0] sum_a, sum_b;
   logic signed [SW-1:0] adj_a, adj_b;
   logic signed [rpv_pkg::COORD_W-1:0] a_ff, b_ff, a_in2, b_in2;

   always_comb begin
      r  = angle[3:0];
      q  = angle[5:4];
      rc = 5'd16 - {1'b0, r};
      t_r_raw = rpv_pkg::cos_q16({1'b0, r});
      t_c_raw = rpv_pkg::cos_q16(rc);
      t_r_rnd = ({1'b0, t_r_raw} + ((18'd1 << SH) >> 1)) >> SH;
      t_c_rnd = ({1'b0, t_c_raw} + ((18'd1 << SH) >> 1)) >> SH;
      t_r = $signed(t_r_rnd[TW-1:0]);
      t_c = $signed(t_c_rnd[TW-1:0]);
      case (q)
         2'd0: begin cs = t_r;  sn = t_c;  end
         2'd1: begin cs = -t_c; sn = t_r;  end
         2'd2: begin cs = -t_r; sn = -t_c; end
         default: begin cs = t_c; sn = -t_r; end
      endcase
      ca_in = PW'(cs * a_in);
      sb_in = PW'(sn * b_in);
      cb_in = PW'(cs * b_in);
      sa_in = PW'(sn * a_in);
      sum_a = SW'(ca_ff) - SW'(sb_ff);
      sum_b = SW'(cb_ff) + SW'(sa_ff);
      adj_a = sum_a + (sum_a[SW-1] ? SW'((1 << FRAC_BITS) - 1) : SW'(0));
      adj_b = sum_b + (sum_b[SW-1] ? SW'((1 << FRAC_BITS) - 1) : SW'(0));
      a_in2 = adj_a[FRAC_BITS +: rpv_pkg::COORD_W];
      b_in2 = adj_b[FRAC_BITS +: rpv_pkg::COORD_W];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff <= ca_in;
         sb_ff <= sb_in;
         cb_ff <= cb_in;
         sa_ff <= sa_in;
         a_ff  <= a_in2;
         b_ff  <= b_in2;
      end
   end

   assign a_out = a_ff;
   assign b_out = b_ff;

endmodule

// ===== hdl/rpv_divide.sv =====
// ----------------------------------------------------------------------------
// rpv_divide
// Pipelined restoring divider: one quotient bit per stage, floor rounding,
// centre add and clamp to 0..255 at the end.
// ----------------------------------------------------------------------------
module rpv_divide (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [rpv_pkg::NUM_W-1:0]         num_mag,
   input  logic                              num_neg,
   input  logic [rpv_pkg::DEN_W-1:0]         den,
   input  logic [7:0]                        center,
   output logic [7:0]                        pixel,
   output logic                              clipped
);

   localparam int NW = rpv_pkg::NUM_W;
   localparam int DW = rpv_pkg::DEN_W;
   localparam int RW = DW + 1;

   logic [NW-1:0] quo_ff [1:NW];
   logic [RW-1:0] rem_ff [1:NW];
   logic [NW-1:0] num_ff [1:NW];
   logic [DW-1:0] den_ff [1:NW];
   logic          neg_ff [1:NW];
   logic [7:0]    ctr_ff [1:NW];

   logic [7:0] pixel_ff, pixel_in;
   logic       clip_ff, clip_in;
   logic signed [NW+2:0] qv, val;

   for (genvar i = 0; i < NW; i++) begin : g_step
      logic [RW-1:0] rem_cur;
      logic [NW-1:0] quo_cur;
      logic [NW-1:0] num_cur;
      logic [DW-1:0] den_cur;
      logic          neg_cur;
      logic [7:0]    ctr_cur;
      logic [RW-1:0] trial;
      logic [RW:0]   diff;
      if (i == 0) begin : g_head
         assign rem_cur = '0;
         assign quo_cur = '0;
         assign num_cur = num_mag;
         assign den_cur = den;
         assign neg_cur = num_neg;
         assign ctr_cur = center;
      end else begin : g_body
         assign rem_cur = rem_ff[i];
         assign quo_cur = quo_ff[i];
         assign num_cur = num_ff[i];
         assign den_cur = den_ff[i];
         assign neg_cur = neg_ff[i];
         assign ctr_cur = ctr_ff[i];
      end
      always_comb begin
         trial = {rem_cur[RW-2:0], num_cur[NW-1-i]};
         diff  = {1'b0, trial} - {2'b00, den_cur};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= diff[RW] ? trial : diff[RW-1:0];
            quo_ff[i+1] <= {quo_cur[NW-2:0], ~diff[RW]};
            num_ff[i+1] <= num_cur;
            den_ff[i+1] <= den_cur;
            neg_ff[i+1] <= neg_cur;
            ctr_ff[i+1] <= ctr_cur;
         end
      end
   end

   always_comb begin
      qv = $signed({3'b000, quo_ff[NW]});
      if (neg_ff[NW]) begin
         qv = -qv - ((rem_ff[NW] != '0) ? (NW+3)'(1) : (NW+3)'(0));
      end
      val = qv + $signed({{(NW-5){1'b0}}, ctr_ff[NW]});
      if (val < 0) begin
         pixel_in = 8'd0;
         clip_in  = 1'b1;
      end else if (val > 255) begin
         pixel_in = 8'd255;
         clip_in  = 1'b1;
      end else begin
         pixel_in = val[7:0];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
         clip_ff  <= clip_in;
      end
   end

   assign pixel   = pixel_ff;
   assign clipped = clip_ff;

endmodule

// ===== hdl/rotate_project_vertex.sv =====
// ----------------------------------------------------------------------------
// rotate_project_vertex
// Rotates a vertex about X, Y and Z and projects it onto an 8-bit screen.
// ----------------------------------------------------------------------------
// One vertex is accepted every cycle while the output is not stalled; each
// result passes through two registers per rotation, the numerator multiply
// register, one per quotient bit of the 20-stage divider and the clamp
// register. A stall freezes the whole pipeline; the output register holds.
module rotate_project_vertex #(
   parameter int TABLE_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [7:0] req_point_x,
   input  logic signed [7:0] req_point_y,
   input  logic signed [7:0] req_point_z,
   input  logic [5:0]  req_angle_x,
   input  logic [5:0]  req_angle_y,
   input  logic [5:0]  req_angle_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_screen_x,
   output logic [7:0]  rsp_screen_y,
   output logic        rsp_off_screen,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [rpv_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW    = rpv_pkg::COORD_W;
   localparam int NW    = rpv_pkg::NUM_W;
   localparam int DW    = rpv_pkg::DEN_W;
   localparam int DEPTH = 6 + 1 + NW + 1;

   logic [7:0]  center_x_ff, center_y_ff;
   logic [11:0] focal_ff, dist_ff;
   logic        wr;
   rpv_pkg::reg_index_type idx;

   logic advance;
   logic [DEPTH-1:0] valid_ff;

   assign pready  = 1'b1;
   assign idx     = rpv_pkg::reg_index_type'(paddr[3:2]);
   assign wr      = psel && penable && pwrite;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= rpv_pkg::CENTER_X_RESET;
         center_y_ff <= rpv_pkg::CENTER_Y_RESET;
         focal_ff    <= rpv_pkg::FOCAL_SCALE_RESET;
         dist_ff     <= rpv_pkg::VIEWER_DISTANCE_RESET;
      end else if (wr) begin
         case (idx)
            rpv_pkg::REG_CENTER_X:    center_x_ff <= pwdata[7:0];
            rpv_pkg::REG_CENTER_Y:    center_y_ff <= pwdata[7:0];
            rpv_pkg::REG_FOCAL_SCALE: focal_ff    <= pwdata[11:0];
            default:                  dist_ff     <= pwdata[11:0];
         endcase
      end
   end

   always_comb begin
      case (idx)
         rpv_pkg::REG_CENTER_X:    prdata = {24'd0, center_x_ff};
         rpv_pkg::REG_CENTER_Y:    prdata = {24'd0, center_y_ff};
         rpv_pkg::REG_FOCAL_SCALE: prdata = {20'd0, focal_ff};
         default:                  prdata = {20'd0, dist_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
      end
   end

   // rotation about X
   logic signed [CW-1:0] x1_ff [0:1];
   logic [5:0] ay1_ff [0:1], az1_ff [0:3];
   logic signed [CW-1:0] y1, z1, x2, z2, x3, y3;
   logic signed [CW-1:0] y2_ff [0:1];
   logic signed [CW-1:0] z2_ff [0:1];

   rpv_rotate #(.FRAC_BITS(TABLE_FRAC_BITS)) u_rot_x (
      .clock(clock), .advance(advance), .angle(req_angle_x),
      .a_in(CW'(req_point_y)), .b_in(CW'(req_point_z)),
      .a_out(y1), .b_out(z1));

   // rotation about Y: x' = c*x + s*z, z' = c*z - s*x
   rpv_rotate #(.FRAC_BITS(TABLE_FRAC_BITS)) u_rot_y (
      .clock(clock), .advance(advance), .angle(ay1_ff[1]),
      .a_in(z1), .b_in(x1_ff[1]),
      .a_out(z2), .b_out(x2));

   rpv_rotate #(.FRAC_BITS(TABLE_FRAC_BITS)) u_rot_z (
      .clock(clock), .advance(advance), .angle(az1_ff[3]),
      .a_in(x2), .b_in(y2_ff[1]),
      .a_out(x3), .b_out(y3));

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff[0]  <= CW'(req_point_x);
         x1_ff[1]  <= x1_ff[0];
         ay1_ff[0] <= req_angle_y;
         ay1_ff[1] <= ay1_ff[0];
         az1_ff[0] <= req_angle_z;
         az1_ff[1] <= az1_ff[0];
         az1_ff[2] <= az1_ff[1];
         az1_ff[3] <= az1_ff[2];
         y2_ff[0]  <= y1;
         y2_ff[1]  <= y2_ff[0];
         z2_ff[0]  <= z2;
         z2_ff[1]  <= z2_ff[0];
      end
   end

   // numerator and denominator
   logic signed [DW:0]   den_s;
   logic signed [NW+1:0] nx_s, ny_s;
   logic [NW-1:0] nxm_ff, nym_ff, nxm_in, nym_in;
   logic          nxn_ff, nyn_ff, behind_ff, behind_in;
   logic [DW-1:0] den_ff, den_in;

   always_comb begin
      den_s  = $signed({2'b00, dist_ff}) - (DW+1)'(z2_ff[1]);
      nx_s   = $signed({1'b0, focal_ff}) * x3;
      ny_s   = $signed({1'b0, focal_ff}) * y3;
      nxm_in = nx_s[NW+1] ? NW'(-nx_s) : nx_s[NW-1:0];
      nym_in = ny_s[NW+1] ? NW'(-ny_s) : ny_s[NW-1:0];
      behind_in = (den_s <= 0);
      den_in = behind_in ? DW'(1) : den_s[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nxm_ff    <= nxm_in;
         nym_ff    <= nym_in;
         nxn_ff    <= nx_s[NW+1];
         nyn_ff    <= ny_s[NW+1];
         den_ff    <= den_in;
         behind_ff <= behind_in;
      end
   end

   logic behind_d_ff [0:NW];
   always_ff @(posedge clock) begin
      if (advance) begin
         behind_d_ff[0] <= behind_ff;
         for (int i = 0; i < NW; i++) begin
            behind_d_ff[i+1] <= behind_d_ff[i];
         end
      end
   end

   logic [7:0] px, py;
   logic       cx, cy;

   rpv_divide u_div_x (
      .clock(clock), .advance(advance), .num_mag(nxm_ff), .num_neg(nxn_ff),
      .den(den_ff), .center(center_x_ff), .pixel(px), .clipped(cx));

   rpv_divide u_div_y (
      .clock(clock), .advance(advance), .num_mag(nym_ff), .num_neg(nyn_ff),
      .den(den_ff), .center(center_y_ff), .pixel(py), .clipped(cy));

   assign rsp_valid      = valid_ff[DEPTH-1];
   assign rsp_screen_x   = behind_d_ff[NW] ? 8'd0 : px;
   assign rsp_screen_y   = behind_d_ff[NW] ? 8'd0 : py;
   assign rsp_off_screen = behind_d_ff[NW] | cx | cy;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_screen_x))
      else $error("stalled result changed");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to output stall");
   a_behind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && behind_d_ff[NW] |-> rsp_off_screen && rsp_screen_x == 8'd0)
      else $error("vertex behind viewer not flagged");

endmodule
